// ===== hdl/rti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray-triangle intersection package
// Shared constants, register indexes and pipeline flag types.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned EPS_BITS       = 16;
  localparam int unsigned CFG_IDX_BITS   = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIR_X     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Y     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Z     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_NEAR_ZERO = 3'd6;

  localparam int unsigned NUM_DOTS = 4;
  localparam int unsigned DOT_DET  = 0;
  localparam int unsigned DOT_NU   = 1;
  localparam int unsigned DOT_NV   = 2;
  localparam int unsigned DOT_NT   = 3;

  typedef struct packed {
    logic valid;
    logic ok;
    logic sat;
  } rti_flags_t;

endpackage

// ===== hdl/rti_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray-triangle front end
// Forms the edges and the origin offset, then the two cross products.
// ----------------------------------------------------------------------------
module rti_front #(
  parameter int unsigned COORD_BITS = rti_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [COORD_BITS-1:0]   vtx_a_i [3],
  input  logic signed [COORD_BITS-1:0]   vtx_b_i [3],
  input  logic signed [COORD_BITS-1:0]   vtx_c_i [3],
  input  logic signed [COORD_BITS-1:0]   org_i   [3],
  input  logic signed [COORD_BITS-1:0]   dir_i   [3],
  output logic                           valid_o,
  output logic signed [COORD_BITS:0]     e1_o    [3],
  output logic signed [COORD_BITS:0]     e2_o    [3],
  output logic signed [COORD_BITS:0]     t_o     [3],
  output logic signed [2*COORD_BITS+1:0] p_o     [3],
  output logic signed [2*COORD_BITS+2:0] q_o     [3]
);

  localparam int unsigned EW = COORD_BITS + 1;
  localparam int unsigned MW = 2 * COORD_BITS + 1;
  localparam int unsigned PW = 2 * COORD_BITS + 2;
  localparam int unsigned QW = PW + 1;

  logic [2:0] vld_q;

  logic signed [EW-1:0] e1_s1_q [3], e2_s1_q [3], t_s1_q [3];
  logic signed [EW-1:0] e1_s2_q [3], e2_s2_q [3], t_s2_q [3];
  logic signed [EW-1:0] e1_s3_q [3], e2_s3_q [3], t_s3_q [3];
  logic signed [MW-1:0] pm_q [3], pn_q [3];
  logic signed [PW-1:0] qm_q [3], qn_q [3];
  logic signed [PW-1:0] p_q [3];
  logic signed [QW-1:0] q_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    always_ff @(posedge clk_i) begin
      e1_s1_q[i] <= {vtx_b_i[i][COORD_BITS-1], vtx_b_i[i]}
                  - {vtx_a_i[i][COORD_BITS-1], vtx_a_i[i]};
      e2_s1_q[i] <= {vtx_c_i[i][COORD_BITS-1], vtx_c_i[i]}
                  - {vtx_a_i[i][COORD_BITS-1], vtx_a_i[i]};
      t_s1_q[i]  <= {org_i[i][COORD_BITS-1], org_i[i]}
                  - {vtx_a_i[i][COORD_BITS-1], vtx_a_i[i]};

      pm_q[i]    <= dir_i[J] * e2_s1_q[K];
      pn_q[i]    <= dir_i[K] * e2_s1_q[J];
      qm_q[i]    <= t_s1_q[J] * e1_s1_q[K];
      qn_q[i]    <= t_s1_q[K] * e1_s1_q[J];
      e1_s2_q[i] <= e1_s1_q[i];
      e2_s2_q[i] <= e2_s1_q[i];
      t_s2_q[i]  <= t_s1_q[i];

      p_q[i]     <= PW'(pm_q[i]) - PW'(pn_q[i]);
      q_q[i]     <= QW'(qm_q[i]) - QW'(qn_q[i]);
      e1_s3_q[i] <= e1_s2_q[i];
      e2_s3_q[i] <= e2_s2_q[i];
      t_s3_q[i]  <= t_s2_q[i];
    end

    assign e1_o[i] = e1_s3_q[i];
    assign e2_o[i] = e2_s3_q[i];
    assign t_o[i]  = t_s3_q[i];
    assign p_o[i]  = p_q[i];
    assign q_o[i]  = q_q[i];
  end

  assign valid_o = vld_q[2];

endmodule

// ===== hdl/rti_dots.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray-triangle dot products
// Computes det, Nu, Nv and Nt with split partial products over four stages.
// ----------------------------------------------------------------------------
module rti_dots #(
  parameter int unsigned COORD_BITS = rti_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [COORD_BITS:0]     e1_i  [3],
  input  logic signed [COORD_BITS:0]     e2_i  [3],
  input  logic signed [COORD_BITS:0]     t_i   [3],
  input  logic signed [COORD_BITS-1:0]   dir_i [3],
  input  logic signed [2*COORD_BITS+1:0] p_i   [3],
  input  logic signed [2*COORD_BITS+2:0] q_i   [3],
  output logic                           valid_o,
  output logic signed [3*COORD_BITS+5:0] dot_o [rti_pkg::NUM_DOTS]
);

  import rti_pkg::*;

  localparam int unsigned EW  = COORD_BITS + 1;
  localparam int unsigned QW  = 2 * COORD_BITS + 3;
  localparam int unsigned H   = COORD_BITS + 1;
  localparam int unsigned HW  = QW - H;
  localparam int unsigned LPW = EW + H + 1;
  localparam int unsigned HPW = EW + HW;
  localparam int unsigned SLW = LPW + 2;
  localparam int unsigned SHW = HPW + 2;
  localparam int unsigned DW  = 3 * COORD_BITS + 6;

  logic [3:0] vld_q;

  logic signed [EW-1:0]  a_w    [NUM_DOTS][3];
  logic signed [QW-1:0]  b_w    [NUM_DOTS][3];
  logic signed [EW-1:0]  a4_q   [NUM_DOTS][3];
  logic signed [HW-1:0]  bh4_q  [NUM_DOTS][3];
  logic signed [LPW-1:0] lo4_q  [NUM_DOTS][3];
  logic signed [LPW-1:0] lo5_q  [NUM_DOTS][3];
  logic signed [HPW-1:0] hi5_q  [NUM_DOTS][3];
  logic signed [SLW-1:0] slo_q  [NUM_DOTS];
  logic signed [SHW-1:0] shi_q  [NUM_DOTS];
  logic signed [DW-1:0]  dot_q  [NUM_DOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_opnd
    assign a_w[DOT_DET][i] = e1_i[i];
    assign b_w[DOT_DET][i] = QW'(p_i[i]);
    assign a_w[DOT_NU][i]  = t_i[i];
    assign b_w[DOT_NU][i]  = QW'(p_i[i]);
    assign a_w[DOT_NV][i]  = EW'(dir_i[i]);
    assign b_w[DOT_NV][i]  = q_i[i];
    assign a_w[DOT_NT][i]  = e2_i[i];
    assign b_w[DOT_NT][i]  = q_i[i];
  end

  for (genvar k = 0; k < NUM_DOTS; k++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_term
      always_ff @(posedge clk_i) begin
        lo4_q[k][i] <= a_w[k][i] * $signed({1'b0, b_w[k][i][H-1:0]});
        a4_q[k][i]  <= a_w[k][i];
        bh4_q[k][i] <= b_w[k][i][QW-1:H];
        hi5_q[k][i] <= a4_q[k][i] * bh4_q[k][i];
        lo5_q[k][i] <= lo4_q[k][i];
      end
    end

    always_ff @(posedge clk_i) begin
      slo_q[k] <= SLW'(lo5_q[k][0]) + SLW'(lo5_q[k][1]) + SLW'(lo5_q[k][2]);
      shi_q[k] <= SHW'(hi5_q[k][0]) + SHW'(hi5_q[k][1]) + SHW'(hi5_q[k][2]);
      dot_q[k] <= DW'(slo_q[k]) + (DW'(shi_q[k]) <<< H);
    end

    assign dot_o[k] = dot_q[k];
  end

  assign valid_o = vld_q[3];

endmodule

// ===== hdl/rti_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray-triangle acceptance tests
// Normalizes the determinant sign and runs the range and saturation checks.
// ----------------------------------------------------------------------------
module rti_test #(
  parameter int unsigned COORD_BITS = rti_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = rti_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic signed [3*COORD_BITS+5:0]  dot_i [rti_pkg::NUM_DOTS],
  input  logic [rti_pkg::EPS_BITS-1:0]    eps_i,
  output rti_pkg::rti_flags_t             flags_o,
  output logic [4*COORD_BITS+4:0]         rem_o,
  output logic [3*COORD_BITS+5:0]         det_o
);

  import rti_pkg::*;

  localparam int unsigned DW = 3 * COORD_BITS + 6;
  localparam int unsigned XW = DW + 1;
  localparam int unsigned CW = DW + 2 * FRAC_BITS + EPS_BITS;
  localparam int unsigned SW = DW + FRAC_BITS + COORD_BITS;
  localparam int unsigned RW = DW + COORD_BITS - 1;

  logic                 vld8_q;
  logic signed [DW-1:0] det8_q, nu8_q, nv8_q, nt8_q;
  logic                 det_zero, det_small, out_uv, t_pos, sat;
  logic signed [XW-1:0] uv_sum;
  logic [SW-1:0]        ns_w;
  rti_flags_t           flags_q;
  logic [RW-1:0]        rem_q;
  logic [DW-1:0]        det_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld8_q  <= 1'b0;
      flags_q <= '0;
    end else begin
      vld8_q        <= valid_i;
      flags_q.valid <= vld8_q;
      flags_q.ok    <= !det_zero && !det_small && !out_uv && t_pos;
      flags_q.sat   <= sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dot_i[DOT_DET][DW-1]) begin
      det8_q <= -dot_i[DOT_DET];
      nu8_q  <= -dot_i[DOT_NU];
      nv8_q  <= -dot_i[DOT_NV];
      nt8_q  <= -dot_i[DOT_NT];
    end else begin
      det8_q <= dot_i[DOT_DET];
      nu8_q  <= dot_i[DOT_NU];
      nv8_q  <= dot_i[DOT_NV];
      nt8_q  <= dot_i[DOT_NT];
    end
    rem_q <= ns_w[RW-1:0];
    det_q <= det8_q;
  end

  always_comb begin
    det_zero  = det8_q == '0;
    det_small = CW'(det8_q) < (CW'(eps_i) << (2 * FRAC_BITS));
    uv_sum    = XW'(nu8_q) + XW'(nv8_q);
    out_uv    = nu8_q[DW-1] || (nu8_q > det8_q) || nv8_q[DW-1] || (uv_sum > XW'(det8_q));
    t_pos     = !nt8_q[DW-1] && (nt8_q != '0);
    ns_w      = SW'(nt8_q) << FRAC_BITS;
    sat       = ns_w >= (SW'(det8_q) << (COORD_BITS - 1));
  end

  assign flags_o = flags_q;
  assign rem_o   = rem_q;
  assign det_o   = det_q;

endmodule

// ===== hdl/rti_divide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray-triangle distance divider
// Restoring division of Nt by det, one quotient bit per stage, then the
// final distance threshold and saturation.
// ----------------------------------------------------------------------------
module rti_divide #(
  parameter int unsigned COORD_BITS = rti_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rti_pkg::rti_flags_t          flags_i,
  input  logic [4*COORD_BITS+4:0]      rem_i,
  input  logic [3*COORD_BITS+5:0]      det_i,
  input  logic [rti_pkg::EPS_BITS-1:0] eps_i,
  output logic                         valid_o,
  output logic                         hit_o,
  output logic [COORD_BITS-2:0]        dist_o
);

  import rti_pkg::*;

  localparam int unsigned DW = 3 * COORD_BITS + 6;
  localparam int unsigned RW = DW + COORD_BITS - 1;
  localparam int unsigned NS = COORD_BITS - 1;
  localparam int unsigned XW = COORD_BITS + EPS_BITS;

  rti_flags_t    flg_q [NS];
  logic [RW-1:0] rem_q [NS];
  logic [DW-1:0] det_q [NS];
  logic [NS-1:0] quo_q [NS];

  logic          hit_w;
  logic          valid_q, hit_q;
  logic [NS-1:0] dist_q;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int unsigned B = NS - 1 - s;

    rti_flags_t    in_flg;
    logic [RW-1:0] in_rem, dsh;
    logic [DW-1:0] in_det;
    logic [NS-1:0] in_quo;
    logic          take;

    if (s == 0) begin : g_first
      assign in_flg = flags_i;
      assign in_rem = rem_i;
      assign in_det = det_i;
      assign in_quo = '0;
    end else begin : g_next
      assign in_flg = flg_q[s-1];
      assign in_rem = rem_q[s-1];
      assign in_det = det_q[s-1];
      assign in_quo = quo_q[s-1];
    end

    always_comb begin
      dsh  = RW'(in_det) << B;
      take = dsh <= in_rem;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        flg_q[s] <= '0;
      end else begin
        flg_q[s] <= in_flg;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= take ? in_rem - dsh : in_rem;
      det_q[s] <= in_det;
      quo_q[s] <= in_quo | (NS'(take) << B);
    end
  end

  always_comb begin
    hit_w = flg_q[NS-1].ok &&
            (flg_q[NS-1].sat || (XW'(quo_q[NS-1]) > XW'(eps_i)) ||
             ((XW'(quo_q[NS-1]) == XW'(eps_i)) && (rem_q[NS-1] != '0)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= flg_q[NS-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_w;
    if (!hit_w) begin
      dist_q <= '0;
    end else if (flg_q[NS-1].sat) begin
      dist_q <= '1;
    end else begin
      dist_q <= quo_q[NS-1];
    end
  end

  assign valid_o = valid_q;
  assign hit_o   = hit_q;
  assign dist_o  = dist_q;

endmodule

// ===== hdl/ray_triangle_intersect_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray-triangle intersection top level
// Throughput: one triangle per cycle; busy stays low, results cannot stall.
// Depth is set by the multiply stages and one divider stage per distance bit.
// Reset clears all valid bits and loads the ray registers with their defaults.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_top #(
  parameter int unsigned COORD_BITS = rti_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = rti_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rti_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]            cfg_data_i,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COORD_BITS-1:0]     vertex_a_x_i,
  input  logic signed [COORD_BITS-1:0]     vertex_a_y_i,
  input  logic signed [COORD_BITS-1:0]     vertex_a_z_i,
  input  logic signed [COORD_BITS-1:0]     vertex_b_x_i,
  input  logic signed [COORD_BITS-1:0]     vertex_b_y_i,
  input  logic signed [COORD_BITS-1:0]     vertex_b_z_i,
  input  logic signed [COORD_BITS-1:0]     vertex_c_x_i,
  input  logic signed [COORD_BITS-1:0]     vertex_c_y_i,
  input  logic signed [COORD_BITS-1:0]     vertex_c_z_i,
  output logic                             result_valid_o,
  output logic                             hit_o,
  output logic [COORD_BITS-2:0]            hit_distance_o
);

  import rti_pkg::*;

  localparam int unsigned EW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * COORD_BITS + 2;
  localparam int unsigned QW = PW + 1;
  localparam int unsigned DW = 3 * COORD_BITS + 6;
  localparam int unsigned RW = DW + COORD_BITS - 1;

  logic signed [COORD_BITS-1:0] org_q [3], dir_q [3];
  logic [EPS_BITS-1:0]          eps_q;

  logic signed [COORD_BITS-1:0] vtx_a [3], vtx_b [3], vtx_c [3];
  logic                         fr_valid, dt_valid;
  logic signed [EW-1:0]         e1 [3], e2 [3], tv [3];
  logic signed [PW-1:0]         pv [3];
  logic signed [QW-1:0]         qv [3];
  logic signed [DW-1:0]         dots [NUM_DOTS];
  rti_flags_t                   tst_flags;
  logic [RW-1:0]                tst_rem;
  logic [DW-1:0]                tst_det;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      dir_q[0] <= '0;
      dir_q[1] <= '0;
      dir_q[2] <= COORD_BITS'(1) << FRAC_BITS;
      eps_q    <= EPS_BITS'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X:  org_q[0] <= cfg_data_i;
        REG_ORIGIN_Y:  org_q[1] <= cfg_data_i;
        REG_ORIGIN_Z:  org_q[2] <= cfg_data_i;
        REG_DIR_X:     dir_q[0] <= cfg_data_i;
        REG_DIR_Y:     dir_q[1] <= cfg_data_i;
        REG_DIR_Z:     dir_q[2] <= cfg_data_i;
        REG_NEAR_ZERO: eps_q    <= cfg_data_i[EPS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign busy = 1'b0;

  assign vtx_a[0] = vertex_a_x_i;
  assign vtx_a[1] = vertex_a_y_i;
  assign vtx_a[2] = vertex_a_z_i;
  assign vtx_b[0] = vertex_b_x_i;
  assign vtx_b[1] = vertex_b_y_i;
  assign vtx_b[2] = vertex_b_z_i;
  assign vtx_c[0] = vertex_c_x_i;
  assign vtx_c[1] = vertex_c_y_i;
  assign vtx_c[2] = vertex_c_z_i;

  rti_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .vtx_a_i (vtx_a),
    .vtx_b_i (vtx_b),
    .vtx_c_i (vtx_c),
    .org_i   (org_q),
    .dir_i   (dir_q),
    .valid_o (fr_valid),
    .e1_o    (e1),
    .e2_o    (e2),
    .t_o     (tv),
    .p_o     (pv),
    .q_o     (qv)
  );

  rti_dots #(.COORD_BITS(COORD_BITS)) u_dots (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .e1_i    (e1),
    .e2_i    (e2),
    .t_i     (tv),
    .dir_i   (dir_q),
    .p_i     (pv),
    .q_i     (qv),
    .valid_o (dt_valid),
    .dot_o   (dots)
  );

  rti_test #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_test (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dt_valid),
    .dot_i   (dots),
    .eps_i   (eps_q),
    .flags_o (tst_flags),
    .rem_o   (tst_rem),
    .det_o   (tst_det)
  );

  rti_divide #(.COORD_BITS(COORD_BITS)) u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (tst_flags),
    .rem_i   (tst_rem),
    .det_i   (tst_det),
    .eps_i   (eps_q),
    .valid_o (result_valid_o),
    .hit_o   (hit_o),
    .dist_o  (hit_distance_o)
  );

endmodule

// ===== hdl/rti_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray-triangle intersection checker
// Port-level properties of the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
module rti_checker #(
  parameter int unsigned COORD_BITS = rti_pkg::COORD_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  result_valid_o,
  input logic                  hit_o,
  input logic [COORD_BITS-2:0] hit_distance_o
);

  localparam int unsigned LATENCY = COORD_BITS + 9;

  // The pipeline never refuses a request.
  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy was asserted");

  // Every accepted request produces its result after the fixed latency.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY result_valid_o)
    else $error("result missing after a request");

  // A miss always reports zero distance.
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !hit_o) |-> (hit_distance_o == '0))
    else $error("miss with nonzero distance");

  // A request-free window keeps the result strobe low.
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!start && $past(rst_ni, LATENCY) && $past(rst_ni, 1)) |-> ##LATENCY
    (!result_valid_o || $past(start, LATENCY)))
    else $error("result without a request");

endmodule

bind ray_triangle_intersect_top rti_checker #(.COORD_BITS(COORD_BITS)) u_rti_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .hit_o          (hit_o),
  .hit_distance_o (hit_distance_o)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray-triangle intersection testbench
// Streams triangles against a configured ray and checks every hit flag and
// distance against an exact wide-integer intersection predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import rti_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef struct packed {
    logic        hit;
    logic [30:0] distance;
  } isect_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic start = 1'b0;
  logic busy;
  logic [8:0][31:0] vert = '0;
  logic result_valid_o, hit_o;
  logic [30:0] hit_distance_o;

  logic [31:0] ray_reg [0:5];
  logic [15:0] eps_reg;
  isect_t isect_q[$];
  int fail_count = 0;
  int item_count = 0;
  int gap_pct = 0;

  always #5 clk_i = ~clk_i;

  ray_triangle_intersect_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .start(start), .busy(busy),
    .vertex_a_x_i(vert[0]), .vertex_a_y_i(vert[1]), .vertex_a_z_i(vert[2]),
    .vertex_b_x_i(vert[3]), .vertex_b_y_i(vert[4]), .vertex_b_z_i(vert[5]),
    .vertex_c_x_i(vert[6]), .vertex_c_y_i(vert[7]), .vertex_c_z_i(vert[8]),
    .result_valid_o(result_valid_o), .hit_o(hit_o), .hit_distance_o(hit_distance_o)
  );

  function automatic wide_t sx(logic [31:0] v);
    wide_t r;
    r = $signed(v);
    return r;
  endfunction

  function automatic isect_t expected_isect(logic [8:0][31:0] v);
    wide_t a[3], e1[3], e2[3], d[3], tv[3], p[3], q[3];
    wide_t det, nu, nv, nt, ns, eps;
    isect_t r;
    r = '0;
    eps = wide_t'(eps_reg);
    for (int i = 0; i < 3; i++) begin
      a[i] = sx(v[i]);
      e1[i] = sx(v[3+i]) - a[i];
      e2[i] = sx(v[6+i]) - a[i];
      d[i] = sx(ray_reg[3+i]);
      tv[i] = sx(ray_reg[i]) - a[i];
    end
    for (int i = 0; i < 3; i++) begin
      p[i] = d[(i+1)%3] * e2[(i+2)%3] - d[(i+2)%3] * e2[(i+1)%3];
      q[i] = tv[(i+1)%3] * e1[(i+2)%3] - tv[(i+2)%3] * e1[(i+1)%3];
    end
    det = 0; nu = 0; nv = 0; nt = 0;
    for (int i = 0; i < 3; i++) begin
      det += e1[i] * p[i];
      nu += tv[i] * p[i];
      nv += d[i] * q[i];
      nt += e2[i] * q[i];
    end
    if (det < 0) begin
      det = -det; nu = -nu; nv = -nv; nt = -nt;
    end
    if (det == 0 || det < (eps <<< 32)) return r;
    if (nu < 0 || nu > det || nv < 0 || nu + nv > det) return r;
    ns = nt <<< 16;
    if (ns <= eps * det) return r;
    r.hit = 1'b1;
    if (ns >= (det <<< 31)) r.distance = '1;
    else r.distance = 31'(ns / det);
    return r;
  endfunction

  task automatic report(string what);
    $display("%0t: error: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (isect_q.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        isect_t e;
        e = isect_q.pop_front();
        if (hit_o !== e.hit) report($sformatf("hit %b, want %b", hit_o, e.hit));
        if (hit_distance_o !== e.distance)
          report($sformatf("distance %h, want %h", hit_distance_o, e.distance));
      end
    end
  end

  task automatic send_triangle(logic [8:0][31:0] v);
    start <= 1'b1;
    vert <= v;
    do @(posedge clk_i); while (busy);
    isect_q = {isect_q, expected_isect(v)};
    item_count++;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (isect_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx < REG_NEAR_ZERO) ray_reg[idx] = data;
    else if (idx == REG_NEAR_ZERO) eps_reg = data[15:0];
  endtask

  task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz, logic [31:0] eps);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    write_reg(REG_NEAR_ZERO, eps);
  endtask

  function automatic logic [8:0][31:0] tri_flat(int ax, ay, ax2, by, cx, cy, int z);
    logic [8:0][31:0] v;
    v = {32'(z), 32'(cy), 32'(cx), 32'(z), 32'(by), 32'(ax2), 32'(z), 32'(ay), 32'(ax)};
    return v;
  endfunction

  task automatic test_directed;
    int u;
    logic [8:0][31:0] v;
    u = 65536;
    send_triangle(tri_flat(-u, -u, u, -u, 0, u, 5 * u));
    send_triangle(tri_flat(-u, -u, 0, u, u, -u, 5 * u));
    send_triangle(tri_flat(-u, -u, u, -u, 0, u, -5 * u));
    send_triangle(tri_flat(0, 0, u, 0, 0, u, 3 * u));
    send_triangle(tri_flat(u, u, 2 * u, u, u, 2 * u, 3 * u));
    send_triangle(tri_flat(-u, -u, u, u, 2 * u, 2 * u, 3 * u));
    send_triangle(tri_flat(-u, -u, u, -u, 0, u, 0));
    send_triangle(tri_flat(-u, -u, u, -u, 0, u, 1));
    v = '0; v[3] = u; v[7] = u; v[2] = 'h7fffffff; v[5] = 'h7fffffff; v[8] = 'h7fffffff;
    send_triangle(v);
    send_triangle('1);
    send_triangle({9{32'h80000000}});
    send_triangle({9{32'h7fffffff}});
    v = {32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
         32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
    send_triangle(v);
    drain();
    // A one-LSB direction makes distant planes overflow the distance field.
    set_ray(0, 0, 0, 0, 0, 1, 0);
    send_triangle(tri_flat(-u, -u, u, -u, 0, u, 'h40000000));
    send_triangle(tri_flat(-u, -u, u, -u, 0, u, 2));
    send_triangle(tri_flat(-u, -u, u, -u, 0, u, 1));
    drain();
    set_ray(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, u, 32'hffffffff);
    write_reg(3'd7, 32'h12345678);
    send_triangle(tri_flat(-u, -u, u, -u, 0, u, 5 * u));
    send_triangle({9{32'h80000000}});
    drain();
    set_ray(0, 0, 0, 0, 0, u, 32'h0001ffff);
    send_triangle(tri_flat(-u, -u, u, -u, 0, u, 5 * u));
    send_triangle(tri_flat(-64 * u, -64 * u, 64 * u, -64 * u, 0, 64 * u, 2 * u));
    drain();
  endtask

  function automatic logic [31:0] rand_span(int sh);
    return 32'($signed($urandom) >>> (31 - sh));
  endfunction

  task automatic test_random(int n);
    logic [8:0][31:0] v;
    logic [31:0] cz;
    int sh;
    if ($urandom_range(3) == 0)
      set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    else
      set_ray(rand_span(18), rand_span(18), rand_span(18), rand_span(12), rand_span(12),
              32'h10000 + rand_span(17), $urandom_range(3) == 0 ? 0 : $urandom_range(255));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(4) == 0) begin
        for (int i = 0; i < 9; i++) v[i] = $urandom;
      end else begin
        sh = $urandom_range(8, 30);
        cz = ray_reg[2] + 32'($urandom_range(1, 64)) * ray_reg[5];
        for (int i = 0; i < 9; i++)
          v[i] = (i % 3 == 2 ? cz + rand_span(sh - 2) : ray_reg[i % 3]) + rand_span(sh);
      end
      send_triangle(v);
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < 6; i++) ray_reg[i] = '0;
    ray_reg[5] = 32'h10000;
    eps_reg = 16'd1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gap_pct = 7;
    test_directed();
    test_random(130);
    test_random(130);
    gap_pct = 65;
    test_random(130);
    test_random(130);
    gap_pct = 0;
    test_random(130);
    test_random(130);
    $display("Sent %0d triangles over directed, random and extreme ray settings,",
             item_count);
    $display("with sender gaps of 7, 65 and 0 percent.");
    if (fail_count == 0) begin
      $display("ray_triangle_intersect_top: match");
    end else begin
      $display("ray_triangle_intersect_top: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("ray_triangle_intersect_top: mismatch");
    $finish;
  end
endmodule
